// ===== rtl/core/fhc_pkg.sv =====
// fhc_pkg: shared constants, types and codes of the frame header checker
// no dependencies; every other file imports it except fhc_channels
`timescale 1ns / 1ps

package fhc_pkg;

   // header layout
   localparam int HEADER_BYTES = 20;
   localparam int CountW       = $clog2(HEADER_BYTES);

   // header queue between front and back
   localparam int QueueDepth = 2;
   localparam int QueueAw    = $clog2(QueueDepth);

   // configuration port
   localparam int AddrW = 4;
   localparam int DataW = 32;

   // register reset values
   localparam logic [31:0] MagicReset   = 32'd0;
   localparam logic [15:0] VersionReset = 16'd1;
   localparam logic [31:0] MaxLenReset  = 32'd1048576;

   // register indexes
   typedef enum logic [1:0] {
      REG_MAGIC   = 2'd0,
      REG_VERSION = 2'd1,
      REG_MAX_LEN = 2'd2
   } fhc_reg_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_MAGIC   = 3'd1,
      ST_BAD_VERSION = 3'd2,
      ST_RESERVED    = 3'd3,
      ST_TOO_LONG    = 3'd4
   } fhc_status_type;

   // configuration bundle
   typedef struct packed {
      logic [31:0] magic_word;
      logic [15:0] expected_version;
      logic [31:0] max_payload;
   } fhc_cfg_type;

   // decoded header fields
   typedef struct packed {
      logic [31:0] magic;
      logic [15:0] version;
      logic [15:0] msg_type;
      logic [15:0] flags;
      logic [15:0] reserved;
      logic [31:0] seq_number;
      logic [31:0] payload_length;
   } fhc_header_type;

endpackage

// ===== rtl/core/fhc_channels.sv =====
// fhc_channels: valid/ready channel interfaces for header bytes and results
// depends on no other file; the status is a plain 3-bit field
`timescale 1ns / 1ps

interface fhc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] header_byte;
   logic       start_mark;

   modport source (output valid, output header_byte, output start_mark, input ready);
   modport sink   (input valid, input header_byte, input start_mark, output ready);
endinterface

interface fhc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] msg_type;
   logic [15:0] flag_bits;
   logic [31:0] seq_number;
   logic [31:0] payload_length;

   modport source (output valid, output status, output msg_type, output flag_bits,
                   output seq_number, output payload_length, input ready);
   modport sink   (input valid, input status, input msg_type, input flag_bits,
                   input seq_number, input payload_length, output ready);
endinterface

// ===== rtl/core/fhc_csr.sv =====
// fhc_csr: APB-style configuration registers of the frame header checker
// depends on fhc_pkg for register indexes, reset values and the config struct
`timescale 1ns / 1ps

module fhc_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [fhc_pkg::AddrW-1:0] paddr,
   input  logic [fhc_pkg::DataW-1:0] pwdata,
   output logic [fhc_pkg::DataW-1:0] prdata,
   output logic                     pready,
   output fhc_pkg::fhc_cfg_type     cfg
);
   import fhc_pkg::*;

   logic [31:0] magic_ff;
   logic [15:0] version_ff;
   logic [31:0] max_len_ff;
   logic        wr_en;
   fhc_reg_type reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = fhc_reg_type'(paddr[AddrW-1:2]);

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= MagicReset;
         version_ff <= VersionReset;
         max_len_ff <= MaxLenReset;
      end else if (wr_en) begin
         case (reg_sel)
            REG_MAGIC:   magic_ff   <= pwdata;
            REG_VERSION: version_ff <= pwdata[15:0];
            REG_MAX_LEN: max_len_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         REG_MAGIC:   prdata = magic_ff;
         REG_VERSION: prdata = {16'd0, version_ff};
         REG_MAX_LEN: prdata = max_len_ff;
         default:     prdata = '0;
      endcase
   end

   assign cfg.magic_word       = magic_ff;
   assign cfg.expected_version = version_ff;
   assign cfg.max_payload      = max_len_ff;

endmodule

// ===== rtl/core/fhc_front.sv =====
// fhc_front: accepts header bytes, tracks position and collects the header
// depends on fhc_pkg and fhc_channels; hands complete headers to the queue
`timescale 1ns / 1ps

module fhc_front (
   input  logic                    clock,
   input  logic                    reset,
   fhc_req_if.sink                 req_chan,
   output logic                    push_valid,
   input  logic                    push_ready,
   output fhc_pkg::fhc_header_type push_hdr
);
   import fhc_pkg::*;

   logic [CountW-1:0] count_ff;
   logic [CountW-1:0] count_in;
   logic [CountW-1:0] idx;
   logic [7:0]        store_ff [HEADER_BYTES];
   logic [7:0]        hdr_bytes [HEADER_BYTES];
   logic              accept;
   logic              last_byte;

   // stall whenever the queue is full, so a completing byte always has room
   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && push_ready;

   // a start mark moves the byte to position zero
   assign idx       = req_chan.start_mark ? '0 : count_ff;
   assign last_byte = (idx == CountW'(HEADER_BYTES - 1));
   assign count_in  = last_byte ? '0 : idx + CountW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   // byte store, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff[idx] <= req_chan.header_byte;
      end
   end

   // full header view: stored bytes plus the incoming last byte
   always_comb begin
      for (int i = 0; i < HEADER_BYTES - 1; i++) begin
         hdr_bytes[i] = store_ff[i];
      end
      hdr_bytes[HEADER_BYTES-1] = req_chan.header_byte;
   end

   // little-endian field split
   assign push_hdr.magic          = {hdr_bytes[3], hdr_bytes[2], hdr_bytes[1], hdr_bytes[0]};
   assign push_hdr.version        = {hdr_bytes[5], hdr_bytes[4]};
   assign push_hdr.msg_type       = {hdr_bytes[7], hdr_bytes[6]};
   assign push_hdr.flags          = {hdr_bytes[9], hdr_bytes[8]};
   assign push_hdr.reserved       = {hdr_bytes[11], hdr_bytes[10]};
   assign push_hdr.seq_number     = {hdr_bytes[15], hdr_bytes[14],
                                     hdr_bytes[13], hdr_bytes[12]};
   assign push_hdr.payload_length = {hdr_bytes[19], hdr_bytes[18],
                                     hdr_bytes[17], hdr_bytes[16]};

   assign push_valid = accept && last_byte;

endmodule

// ===== rtl/core/fhc_queue.sv =====
// fhc_queue: short header queue between the front and the back
// depends on fhc_pkg for the header type and queue depth
`timescale 1ns / 1ps

module fhc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  fhc_pkg::fhc_header_type push_hdr,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output fhc_pkg::fhc_header_type pop_hdr
);
   import fhc_pkg::*;

   fhc_header_type     mem_ff [QueueDepth];
   logic [QueueAw-1:0] wr_ptr_ff;
   logic [QueueAw-1:0] rd_ptr_ff;
   logic [QueueAw:0]   cnt_ff;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (cnt_ff != (QueueAw+1)'(QueueDepth));
   assign pop_valid  = (cnt_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_hdr    = mem_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QueueAw'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QueueAw'(1);
         case ({do_push, do_pop})
            2'b10:   cnt_ff <= cnt_ff + (QueueAw+1)'(1);
            2'b01:   cnt_ff <= cnt_ff - (QueueAw+1)'(1);
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_hdr;
      end
   end

endmodule

// ===== rtl/core/fhc_back.sv =====
// fhc_back: runs the header checks and holds the result item for the sink
// depends on fhc_pkg and fhc_channels
`timescale 1ns / 1ps

module fhc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  fhc_pkg::fhc_cfg_type    cfg,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  fhc_pkg::fhc_header_type pop_hdr,
   fhc_rsp_if.source               rsp_chan
);
   import fhc_pkg::*;

   logic           valid_ff;
   fhc_status_type status_ff;
   fhc_status_type status_in;
   logic [15:0]    type_ff;
   logic [15:0]    flags_ff;
   logic [31:0]    seq_ff;
   logic [31:0]    len_ff;
   logic           load;
   logic           pass;

   // take a new header when the output slot is empty or being drained
   assign pop_ready = !valid_ff || rsp_chan.ready;
   assign load      = pop_valid && pop_ready;

   // checks in priority order, first failure wins
   always_comb begin
      if (pop_hdr.magic != cfg.magic_word) begin
         status_in = ST_BAD_MAGIC;
      end else if (pop_hdr.version != cfg.expected_version) begin
         status_in = ST_BAD_VERSION;
      end else if (pop_hdr.reserved != 16'd0) begin
         status_in = ST_RESERVED;
      end else if (pop_hdr.payload_length > cfg.max_payload) begin
         status_in = ST_TOO_LONG;
      end else begin
         status_in = ST_OK;
      end
   end

   assign pass = (status_in == ST_OK);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop_ready) begin
         valid_ff <= pop_valid;
      end
   end

   // result payload; fields are zero on a failed check
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         type_ff   <= pass ? pop_hdr.msg_type       : 16'd0;
         flags_ff  <= pass ? pop_hdr.flags          : 16'd0;
         seq_ff    <= pass ? pop_hdr.seq_number     : 32'd0;
         len_ff    <= pass ? pop_hdr.payload_length : 32'd0;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.msg_type       = type_ff;
   assign rsp_chan.flag_bits      = flags_ff;
   assign rsp_chan.seq_number     = seq_ff;
   assign rsp_chan.payload_length = len_ff;

endmodule

// ===== rtl/core/frame_header_checker.sv =====
// frame_header_checker: top level, one header byte accepted per cycle unless stalled
// path: after the last header byte is taken, the header is written to a queue entry,
// then checked and held in the result register
// throughput: one byte per cycle while the queue has room, set by the byte counter and store in the front
// a stalled sink stops intake only once the result register and both queue entries are full
// reset: synchronous, active high; clears byte count, queue and result valid,
// registers return to magic 0, version 1, max payload 1048576
`timescale 1ns / 1ps

module frame_header_checker (
   input  logic                      clock,
   input  logic                      reset,
   fhc_req_if.sink                   req_chan,
   fhc_rsp_if.source                 rsp_chan,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [fhc_pkg::AddrW-1:0] paddr,
   input  logic [fhc_pkg::DataW-1:0] pwdata,
   output logic [fhc_pkg::DataW-1:0] prdata,
   output logic                      pready
);
   import fhc_pkg::*;

   fhc_cfg_type    cfg;
   logic           push_valid;
   logic           push_ready;
   fhc_header_type push_hdr;
   logic           pop_valid;
   logic           pop_ready;
   fhc_header_type pop_hdr;

   // configuration registers
   fhc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // byte intake and header assembly
   fhc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_hdr   (push_hdr)
   );

   // decoupling queue
   fhc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_hdr   (push_hdr),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_hdr    (pop_hdr)
   );

   // checks and result register
   fhc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_hdr   (pop_hdr),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== rtl/core/fhc_checker.sv =====
// fhc_checker: port-level assertions for frame_header_checker
// depends on fhc_pkg for status codes; bound to the top level below
`timescale 1ns / 1ps

module fhc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_msg_type,
   input logic [15:0] rsp_flag_bits,
   input logic [31:0] rsp_seq_number,
   input logic [31:0] rsp_payload_length,
   input logic        pready
);
   import fhc_pkg::*;

   // no result item right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item valid after reset");

   // a stalled result item holds its status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result item changed");

   // failed checks carry zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_msg_type == 16'd0 && rsp_flag_bits == 16'd0
         && rsp_seq_number == 32'd0 && rsp_payload_length == 32'd0)
      else $error("failed header carries nonzero fields");

   // status code stays within the defined set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_TOO_LONG)
      else $error("status code out of range");

   // configuration port never waits
   assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind frame_header_checker fhc_checker u_fhc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_status         (rsp_chan.status),
   .rsp_msg_type       (rsp_chan.msg_type),
   .rsp_flag_bits      (rsp_chan.flag_bits),
   .rsp_seq_number     (rsp_chan.seq_number),
   .rsp_payload_length (rsp_chan.payload_length),
   .pready             (pready)
);
